// ===== hdl/scrd_pkg.sv =====
package scrd_pkg;

  // Number of decoded commands held between the parser and the expander.
  localparam int unsigned QueueDepth = 2;

  // Parser state, one-hot.
  typedef enum logic [2:0] {
    ModeHeader  = 3'b001,
    ModeLiteral = 3'b010,
    ModeRepeat  = 3'b100
  } parse_mode_e;

  // One command for the expander: either a single result or a repeat run.
  typedef struct packed {
    logic       is_run;    // Repeat run of len_m1 + 1 copies of data.
    logic [7:0] data;      // Literal byte or byte to repeat.
    logic [1:0] cnt;       // Byte count of a single result.
    logic       trunc;     // Truncated flag of a single result.
    logic [6:0] len_m1;    // Run length minus one.
  } cmd_t;

endpackage

// ===== hdl/scrd_in_if.sv =====
interface scrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

// ===== hdl/scrd_out_if.sv =====
interface scrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic       run_done;
  logic       truncated;

  modport source (
    output valid, output first_byte, output second_byte, output byte_count,
    output run_done, output truncated, input ready
  );
  modport sink (
    input valid, input first_byte, input second_byte, input byte_count,
    input run_done, input truncated, output ready
  );
endinterface

// ===== hdl/scrd_front.sv =====
module scrd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  scrd_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output scrd_pkg::cmd_t  cmd_o
);
  import scrd_pkg::*;

  parse_mode_e mode_q, mode_d;
  logic [7:0]  pend_q, pend_d;
  logic        accept;

  // A beat is taken whenever the command queue has room.
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the byte by parser state and build the command for the back end.
  always_comb begin
    mode_d       = mode_q;
    pend_d       = pend_q;
    push_o       = 1'b0;
    cmd_o        = '0;
    if (accept) begin
      case (mode_q)
        ModeLiteral: begin
          push_o      = 1'b1;
          cmd_o.data  = in_i.data_byte;
          cmd_o.cnt   = 2'd1;
          cmd_o.trunc = in_i.block_end && (pend_q > 8'd1);
          if (pend_q > 8'd1) begin
            pend_d = pend_q - 8'd1;
          end else begin
            mode_d = ModeHeader;
            pend_d = '0;
          end
        end
        ModeRepeat: begin
          push_o       = 1'b1;
          cmd_o.is_run = 1'b1;
          cmd_o.data   = in_i.data_byte;
          cmd_o.len_m1 = pend_q[6:0];
          mode_d       = ModeHeader;
          pend_d       = '0;
        end
        default: begin
          if (!in_i.data_byte[7]) begin
            mode_d = ModeLiteral;
            pend_d = in_i.data_byte + 8'd1;
          end else begin
            // Negative count: repeat count minus one is 255 - byte.
            mode_d = ModeRepeat;
            pend_d = ~in_i.data_byte;
          end
          if (in_i.block_end) begin
            push_o      = 1'b1;
            cmd_o.trunc = 1'b1;
          end
        end
      endcase
      // The end of a block always returns the parser to header state.
      if (in_i.block_end) begin
        mode_d = ModeHeader;
        pend_d = '0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeHeader;
      pend_q <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
    end
  end

`ifndef SYNTHESIS
  a_end_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.block_end) |=> (mode_q == ModeHeader && pend_q == '0))
    else $error("parser not in header state after end of block");
`endif

endmodule

// ===== hdl/scrd_fifo.sv =====
module scrd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scrd_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output scrd_pkg::cmd_t  cmd_o,
  output logic            full_o,
  output logic            empty_o
);
  import scrd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(QueueDepth))
    else $error("command queue fill count out of range");
`endif

endmodule

// ===== hdl/scrd_back.sv =====
module scrd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scrd_pkg::cmd_t  cmd_i,
  input  logic            empty_i,
  output logic            pop_o,
  scrd_out_if.source      out_o
);
  import scrd_pkg::*;

  logic       active_q, active_d;
  cmd_t       cmd_q, cmd_d;
  logic [7:0] left_q, left_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] first_q, first_d, second_q, second_d;
  logic [1:0] count_q, count_d;
  logic       done_q, done_d, trunc_q, trunc_d;
  logic       advance, emit, two;

  // The output register is free when empty or being taken this cycle.
  assign advance = !out_valid_q || out_o.ready;
  assign emit    = active_q && advance;
  assign pop_o   = !active_q && !empty_i;
  assign two     = (left_q >= 8'd2);

  // Expand the current command into result beats.
  always_comb begin
    active_d    = active_q;
    cmd_d       = cmd_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    first_d     = first_q;
    second_d    = second_q;
    count_d     = count_q;
    done_d      = done_q;
    trunc_d     = trunc_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      first_d     = cmd_q.data;
      if (cmd_q.is_run) begin
        // Two copies per beat, one on the last beat of an odd run.
        left_d   = left_q - (two ? 8'd2 : 8'd1);
        second_d = two ? cmd_q.data : 8'd0;
        count_d  = two ? 2'd2 : 2'd1;
        done_d   = (left_q == 8'd1) || (left_q == 8'd2);
        trunc_d  = 1'b0;
      end else begin
        left_d   = '0;
        second_d = 8'd0;
        count_d  = cmd_q.cnt;
        done_d   = 1'b1;
        trunc_d  = cmd_q.trunc;
      end
      active_d = !done_d;
    end
    // Take the next command once the current one is finished.
    if (pop_o) begin
      active_d = 1'b1;
      cmd_d    = cmd_i;
      left_d   = {1'b0, cmd_i.len_m1} + 8'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    left_q   <= left_d;
    first_q  <= first_d;
    second_q <= second_d;
    count_q  <= count_d;
    done_q   <= done_d;
    trunc_q  <= trunc_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.first_byte  = first_q;
  assign out_o.second_byte = second_q;
  assign out_o.byte_count  = count_q;
  assign out_o.run_done    = done_q;
  assign out_o.truncated   = trunc_q;

`ifndef SYNTHESIS
  a_run_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && cmd_q.is_run) |-> (left_q != 8'd0 && left_q <= 8'd128))
    else $error("run length out of range while expanding");
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && count_q == 2'd0) |-> (trunc_q && done_q))
    else $error("empty result beat without truncation");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !done_d && emit) |=> active_q)
    else $error("expander dropped an unfinished run");
`endif

endmodule

// ===== hdl/signed_count_rle_decoder.sv =====
// Channel | Dir | Beat contents
// in_i    | in  | data_byte[7:0], block_end
// out_o   | out | first_byte[7:0], second_byte[7:0], byte_count[1:0], run_done, truncated
//
// Header and literal bytes are taken at one per cycle while the command queue has room.
// A repeat byte of n copies is expanded into ceil(n/2) output beats (up to 64 for n = 128),
// and each command is first loaded into the expander from the two-entry queue.
// The output register lets the expander run one beat ahead of a stalled sink.
// Reset (asynchronous, active low) returns the parser to header state and empties the queue.
module signed_count_rle_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  scrd_in_if.sink     in_i,
  scrd_out_if.source  out_o
);
  import scrd_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  // Header parsing and command build.
  scrd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // Short command queue between parser and expander.
  scrd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  // Run expansion and output register.
  scrd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/signed_count_rle_decoder_tb.sv =====
`timescale 1ns / 1ps

module signed_count_rle_decoder_tb;
  import scrd_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned HoldCycles = 400;

  // One decoded output beat, laid out as the output channel carries it.
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       run_done;
    logic       truncated;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  scrd_in_if  in_if ();
  scrd_out_if out_if ();

  signed_count_rle_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Decoder state mirrored by the predictor.
  parse_mode_e dec_mode = ModeHeader;
  logic [7:0]  dec_pending = 8'h00;
  decoded_t    expected_beats[$];

  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;

  // Sender burst control and receiver stall control.
  bit tx_gaps = 1'b1;
  int tx_burst = 0;
  int rx_hold = 0;
  int rx_mode = 0;
  int rx_span = 0;

  // Work out the output beats caused by one accepted compressed byte.
  task automatic predict_decode(input logic [7:0] b, input logic e);
    int unsigned left;
    logic [1:0]  c;
    decoded_t    r;
    case (dec_mode)
      ModeLiteral: begin
        r = '{first_byte: b, second_byte: 8'h00, byte_count: 2'd1, run_done: 1'b1,
              truncated: e && (dec_pending > 8'd1)};
        expected_beats.push_back(r);
        if (dec_pending > 8'd1) begin
          dec_pending = dec_pending - 8'd1;
        end else begin
          dec_mode = ModeHeader;
          dec_pending = 8'h00;
        end
      end
      ModeRepeat: begin
        // The run is pending + 1 copies, two per beat, the odd one last.
        left = int'(dec_pending) + 1;
        while (left > 0) begin
          c = (left >= 2) ? 2'd2 : 2'd1;
          left = left - 32'(c);
          r = '{first_byte: b, second_byte: (c == 2'd2) ? b : 8'h00, byte_count: c,
                run_done: (left == 0), truncated: 1'b0};
          expected_beats.push_back(r);
        end
        dec_mode = ModeHeader;
        dec_pending = 8'h00;
      end
      default: begin
        // A header is a signed count: non-negative means literals, negative a run.
        if (!b[7]) begin
          dec_mode = ModeLiteral;
          dec_pending = b + 8'd1;
        end else begin
          dec_mode = ModeRepeat;
          dec_pending = ~b;
        end
        if (e) begin
          r = '{first_byte: 8'h00, second_byte: 8'h00, byte_count: 2'd0, run_done: 1'b1,
                truncated: 1'b1};
          expected_beats.push_back(r);
        end
      end
    endcase
    if (e) begin
      dec_mode = ModeHeader;
      dec_pending = 8'h00;
    end
  endtask

  // Offer one byte and wait until the block takes it. Valid stays high while a
  // burst goes on, so the next call follows in the same step.
  task automatic send_byte(input logic [7:0] b, input logic e);
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.block_end <= e;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    predict_decode(b, e);
    if (tx_gaps) begin
      if (tx_burst > 0) begin
        tx_burst--;
      end else begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        tx_burst = $urandom_range(0, 15);
      end
    end
  endtask

  // Close the current burst and let every expected beat come out.
  task automatic wait_drain();
    if (in_if.valid) in_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  // Compare each output beat with the oldest expectation.
  always @(posedge clk_i) begin
    decoded_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %0h %0h %0d %0b %0b", $time,
                 out_if.first_byte, out_if.second_byte, out_if.byte_count, out_if.run_done,
                 out_if.truncated);
        mismatch_cnt++;
      end else begin
        exp_r = expected_beats.pop_front();
        check_field("first_byte", 32'(exp_r.first_byte), 32'(out_if.first_byte));
        check_field("second_byte", 32'(exp_r.second_byte), 32'(out_if.second_byte));
        check_field("byte_count", 32'(exp_r.byte_count), 32'(out_if.byte_count));
        check_field("run_done", 32'(exp_r.run_done), 32'(out_if.run_done));
        check_field("truncated", 32'(exp_r.truncated), 32'(out_if.truncated));
      end
    end
  end

  // Receiver: a long hold when requested, otherwise stretches of different stall patterns.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_span = $urandom_range(20, 200);
      end
      rx_span--;
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= (cycle_cnt % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Literal packets: the shortest one and one of three bytes, with extreme byte values.
  task automatic test_literal_packets();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_drain();
  endtask

  // Repeat runs of one, two and three copies, and the full run of 128.
  task automatic test_repeat_packets();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_drain();
  endtask

  // Block end on a header, inside literals, on the last literal and on a run byte.
  task automatic test_block_end();
    send_byte(8'h05, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'h96, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h69, 1'b1);
    wait_drain();
  endtask

  // Hold the receiver off while long runs keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold = HoldCycles;
    repeat (4) begin
      send_byte(8'h80, 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    send_byte(8'h07, 1'b0);
    repeat (8) send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drain();
    tx_gaps = 1'b1;
  endtask

  // Packet length: mostly short, sometimes long, now and then the maximum of 128.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 128;
    if (r < 3) return $urandom_range(9, 128);
    return $urandom_range(1, 8);
  endfunction

  // Mostly well-formed blocks with random content, some cut short, some noise.
  task automatic test_random_blocks();
    logic [7:0]  blk_q[$];
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    while (items_sent < RandomItems) begin
      blk_q.delete();
      kind = $urandom_range(0, 9);
      tx_gaps = ($urandom_range(0, 3) != 0);
      if (kind == 0) begin
        repeat ($urandom_range(1, 12)) begin
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          len = pick_len();
          if ($urandom_range(0, 1) == 0) begin
            blk_q.push_back(8'(len - 1));
            repeat (len) blk_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            blk_q.push_back(8'(256 - len));
            blk_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        // A broken block ends at a random byte instead of its last one.
        cut = (kind == 1) ? $urandom_range(0, blk_q.size() - 1) : blk_q.size() - 1;
        for (int unsigned i = 0; i <= cut; i++) begin
          send_byte(blk_q[i], (i == cut));
        end
      end
    end
    wait_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.block_end = 1'b0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_literal_packets();
    test_repeat_packets();
    test_block_end();
    test_backpressure();
    test_random_blocks();
    if (mismatch_cnt == 0 && expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
